/* rtl/acm_pkg.sv */
// Shared types, constants and the cosine table generator for the
// analog carrier modulator. No dependencies.
`default_nettype none

package acm_pkg;

  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int TABLE_ADDR_BITS_DEF = 10;
  localparam int PHASE_BITS          = 32;
  localparam int OFFSET_BITS         = 16;
  localparam int COS_BITS            = 17;
  localparam int OUT_BITS            = 17;
  localparam int CFG_ADDR_BITS       = 3;
  localparam int CFG_DATA_BITS       = 32;
  localparam int PIPE_DEPTH          = 7;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    MODE_AM_SC      = 2'd0,
    MODE_AM_CARRIER = 2'd1,
    MODE_FM         = 2'd2,
    MODE_PM         = 2'd3
  } mode_t;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_MODE       = 3'd0,
    REG_FREQ_WORD  = 3'd1,
    REG_PHASE_WORD = 3'd2,
    REG_OFFSET     = 3'd3,
    REG_ANGLE_GAIN = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    mode_t                         mode;
    logic [PHASE_BITS-1:0]         freq_word;
    logic [PHASE_BITS-1:0]         phase_word;
    logic signed [OFFSET_BITS-1:0] carrier_offset;
    logic [PHASE_BITS-1:0]         angle_gain;
  } acm_cfg_t;

  // Restoring long division; it runs only while the table is built.
  function automatic longint unsigned udiv_u64(input longint unsigned num,
                                               input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    int              i;
    q = '0;
    r = '0;
    for (i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r    = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // One entry of the quarter-wave table: 32767*cos(pi/2 * k / 2^abits),
  // evaluated as a Q30 Taylor series, clamped and rounded to Q1.15.
  function automatic logic [15:0] cos_entry(input int unsigned k, input int unsigned abits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned dv;
    longint unsigned scaled;
    longint          sum;
    int unsigned     n;
    x    = (HALF_PI_Q30 * 64'(k)) >> abits;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = longint'(term);
    for (n = 1; n <= 12; n++) begin
      dv   = 64'((2 * n - 1) * (2 * n));
      term = udiv_u64((term * x2) >> 30, dv);
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (longint'(1) << 30)) begin
      sum = longint'(1) << 30;
    end
    scaled = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    return scaled[15:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/acm_phase.sv */
// Carrier and FM phase accumulators plus the angle gain multiply.
// Three register stages; depends on acm_pkg.
`default_nettype none

module acm_phase import acm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int VAL_BITS    = OFFSET_BITS + 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          accept,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  input  wire logic                          block_start_i,
  input  wire acm_cfg_t                      cfg,
  output logic [PHASE_BITS-1:0]              ang_o,
  output logic signed [VAL_BITS-1:0]         val_o,
  output mode_t                              mode_o
);

  logic [PHASE_BITS-1:0] carrier_phase_r, carrier_phase_nxt;
  logic [PHASE_BITS-1:0] fm_phase_r, fm_phase_nxt;
  logic [PHASE_BITS-1:0] cp_now, xw, fm_sum;

  logic [PHASE_BITS-1:0]         ang1_r, mul1_r;
  logic signed [SAMPLE_BITS-1:0] x1_r;
  mode_t                         mode1_r;

  logic [PHASE_BITS-1:0]      ang2_r, prod2_r;
  logic signed [VAL_BITS-1:0] val2_r, val2_nxt;
  mode_t                      mode2_r;

  logic [PHASE_BITS-1:0]      ang3_r, ang3_nxt;
  logic signed [VAL_BITS-1:0] val3_r;
  mode_t                      mode3_r;

  always_comb begin
    cp_now            = block_start_i ? '0 : carrier_phase_r;
    xw                = PHASE_BITS'(sample_i);
    fm_sum            = fm_phase_r + xw;
    carrier_phase_nxt = cp_now + cfg.freq_word;
    fm_phase_nxt      = (cfg.mode == MODE_FM) ? fm_sum : fm_phase_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_phase_r <= '0;
      fm_phase_r      <= '0;
    end else if (accept) begin
      carrier_phase_r <= carrier_phase_nxt;
      fm_phase_r      <= fm_phase_nxt;
    end
  end

  always_comb begin
    if (mode1_r == MODE_AM_CARRIER) begin
      val2_nxt = VAL_BITS'(x1_r) - VAL_BITS'(cfg.carrier_offset);
    end else begin
      val2_nxt = VAL_BITS'(x1_r);
    end
    if (mode2_r == MODE_FM || mode2_r == MODE_PM) begin
      ang3_nxt = ang2_r + prod2_r;
    end else begin
      ang3_nxt = ang2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang1_r  <= cp_now + cfg.phase_word;
      mul1_r  <= (cfg.mode == MODE_FM) ? fm_sum : xw;
      x1_r    <= sample_i;
      mode1_r <= cfg.mode;

      // Only the low word of the product matters: angles wrap.
      prod2_r <= cfg.angle_gain * mul1_r;
      ang2_r  <= ang1_r;
      val2_r  <= val2_nxt;
      mode2_r <= mode1_r;

      ang3_r  <= ang3_nxt;
      val3_r  <= val2_r;
      mode3_r <= mode2_r;
    end
  end

  assign ang_o  = ang3_r;
  assign val_o  = val3_r;
  assign mode_o = mode3_r;

endmodule

`default_nettype wire

/* rtl/acm_cos.sv */
// Quarter-wave cosine ROM with quadrant folding; two register stages.
// Depends on acm_pkg for the table generator.
`default_nettype none

module acm_cos import acm_pkg::*; #(
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [PHASE_BITS-1:0] ang_i,
  output logic signed [COS_BITS-1:0] cos_o
);

  localparam int TBL_N = 1 << TABLE_ADDR_BITS;
  localparam logic [TABLE_ADDR_BITS:0] TBL_N_VAL = (TABLE_ADDR_BITS + 1)'(TBL_N);

  logic [15:0] rom [TBL_N + 1];

  for (genvar k = 0; k <= TBL_N; k++) begin : g_rom
    localparam logic [15:0] ENTRY = cos_entry(k, TABLE_ADDR_BITS);
    assign rom[k] = ENTRY;
  end

  logic [1:0]                 quad;
  logic [TABLE_ADDR_BITS-1:0] frac;
  logic [TABLE_ADDR_BITS:0]   addr;
  logic [15:0]                rom_q_r;
  logic                       neg_r;
  logic signed [COS_BITS-1:0] mag, cos_r;

  always_comb begin
    quad = ang_i[PHASE_BITS-1 -: 2];
    frac = ang_i[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    // Odd quadrants read the table mirrored.
    addr = quad[0] ? (TBL_N_VAL - {1'b0, frac}) : {1'b0, frac};
    mag  = signed'({1'b0, rom_q_r});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rom_q_r <= rom[addr];
      neg_r   <= quad[1] ^ quad[0];
      cos_r   <= neg_r ? -mag : mag;
    end
  end

  assign cos_o = cos_r;

endmodule

`default_nettype wire

/* rtl/acm_mix.sv */
// Amplitude multiply, Q15 rounding and mode select; four register stages.
// Depends on acm_pkg.
`default_nettype none

module acm_mix import acm_pkg::*; #(
  parameter int VAL_BITS = OFFSET_BITS + 1
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic signed [VAL_BITS-1:0] val_i,
  input  wire mode_t                      mode_i,
  input  wire logic signed [COS_BITS-1:0] cos_i,
  output logic signed [OUT_BITS-1:0]      modulated_o
);

  localparam int PROD_BITS = VAL_BITS + COS_BITS;
  localparam logic signed [PROD_BITS-1:0] HALF_LSB = PROD_BITS'(16384);

  logic signed [VAL_BITS-1:0]  val4_r, val5_r;
  mode_t                       mode4_r, mode5_r, mode6_r;
  logic signed [PROD_BITS-1:0] prod6_r, rnd;
  logic signed [COS_BITS-1:0]  cos6_r;
  logic signed [OUT_BITS-1:0]  out_r, out_nxt;

  always_comb begin
    // Adding one half before dropping 15 bits rounds ties upward.
    rnd = prod6_r + HALF_LSB;
    if (mode6_r == MODE_AM_SC || mode6_r == MODE_AM_CARRIER) begin
      out_nxt = rnd[15 +: OUT_BITS];
    end else begin
      out_nxt = OUT_BITS'(cos6_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val4_r  <= val_i;
      mode4_r <= mode_i;
      val5_r  <= val4_r;
      mode5_r <= mode4_r;
      prod6_r <= PROD_BITS'(val5_r) * PROD_BITS'(cos_i);
      cos6_r  <= cos_i;
      mode6_r <= mode5_r;
      out_r   <= out_nxt;
    end
  end

  assign modulated_o = out_r;

endmodule

`default_nettype wire

/* rtl/analog_carrier_modulator.sv */
// Top level of the NCO based AM / FM / PM modulator.
// Depends on acm_pkg, acm_phase, acm_cos and acm_mix.
//
// Usage: one signed message sample enters per beat on the in_ stream
// (in_tdata holds the sample, in_tuser the block start flag) and one
// modulated sample leaves per beat on the out_ stream (out_tdata, 17 bits
// signed, zero filled to 24 bits). Registers are written through the cfg_
// port while the stream is idle; indexes follow cfg_reg_t in the package.
// Throughput is one sample per clock while out_tready is high. Each input
// beat reaches out_tvalid through the pipeline: phase accumulate, angle gain
// multiply, angle add, cosine ROM read, quadrant sign, amplitude multiply
// and the output register. The whole pipeline advances together; when the
// receiver holds out_tready low with a result waiting, every stage holds
// and in_tready drops. in_tready stays high whenever the output stage is
// empty, even if the receiver is not ready.
// Reset clears the cfg registers, both phase accumulators and the valid bits;
// the cosine table is constant and needs no fill.
`default_nettype none

module analog_carrier_modulator import acm_pkg::*; #(
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  input  wire logic [(((SAMPLE_BITS+7)>>3)<<3)-1:0]   in_tdata,   // sample
  input  wire logic [0:0]                             in_tuser,   // block_start
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  output logic [23:0]                                 out_tdata,  // modulated
  input  wire logic                                   cfg_we,
  input  wire logic [CFG_ADDR_BITS-1:0]               cfg_addr,
  input  wire logic [CFG_DATA_BITS-1:0]               cfg_wdata
);

  localparam int VAL_BITS =
    ((SAMPLE_BITS > OFFSET_BITS) ? SAMPLE_BITS : OFFSET_BITS) + 1;

  acm_cfg_t                   cfg_r;
  logic [PIPE_DEPTH-1:0]      vld_r;
  logic                       en, accept;
  logic [PHASE_BITS-1:0]      ang;
  logic signed [VAL_BITS-1:0] val;
  mode_t                      mode;
  logic signed [COS_BITS-1:0] cos_val;
  logic signed [OUT_BITS-1:0] modulated;

  assign en     = !vld_r[PIPE_DEPTH-1] || out_tready;
  assign accept = in_tvalid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MODE:       cfg_r.mode           <= mode_t'(cfg_wdata[1:0]);
        REG_FREQ_WORD:  cfg_r.freq_word      <= cfg_wdata;
        REG_PHASE_WORD: cfg_r.phase_word     <= cfg_wdata;
        REG_OFFSET:     cfg_r.carrier_offset <= signed'(cfg_wdata[OFFSET_BITS-1:0]);
        REG_ANGLE_GAIN: cfg_r.angle_gain     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_tvalid};
    end
  end

  acm_phase #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .VAL_BITS    (VAL_BITS)
  ) u_phase (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .accept        (accept),
    .sample_i      (signed'(in_tdata[SAMPLE_BITS-1:0])),
    .block_start_i (in_tuser[0]),
    .cfg           (cfg_r),
    .ang_o         (ang),
    .val_o         (val),
    .mode_o        (mode)
  );

  acm_cos #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_cos (
    .clk   (clk),
    .en    (en),
    .ang_i (ang),
    .cos_o (cos_val)
  );

  acm_mix #(
    .VAL_BITS (VAL_BITS)
  ) u_mix (
    .clk         (clk),
    .en          (en),
    .val_i       (val),
    .mode_i      (mode),
    .cos_i       (cos_val),
    .modulated_o (modulated)
  );

  assign in_tready  = en;
  assign out_tvalid = vld_r[PIPE_DEPTH-1];
  assign out_tdata  = {{(24 - OUT_BITS){1'b0}}, modulated};

endmodule

`default_nettype wire

/* tb/tb_analog_carrier_modulator.sv */
`timescale 1ns / 1ps
// Self-checking testbench for analog_carrier_modulator: predicts each modulated beat
// from the configured mode, carrier phase and FM running sum, then checks the output stream.
// Depends on acm_pkg and the modulator RTL.

module tb_analog_carrier_modulator;
  import acm_pkg::*;

  localparam int TBL_BITS       = 10;
  localparam int TBL_N          = 1 << TBL_BITS;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int CHUNKS         = 12;
  localparam int CHUNK_BEATS    = 50;

  // Predicts and checks the modulated sample stream.
  class modulated_sample_board;
    mode_t            mode;
    bit [31:0]        freq_word;
    bit [31:0]        phase_word;
    bit signed [15:0] carrier_offset;
    bit [31:0]        angle_gain;
    bit [31:0]        carrier_phase;
    bit [31:0]        fm_sum;
    int               cos_quarter[0:TBL_N];
    logic [16:0]      expected_modulated[$];
    int               mismatches;
    int               checked;
    int               block_starts;
    int               mode_samples[4];

    function new();
      longint unsigned xr;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      for (int k = 0; k <= TBL_N; k++) begin
        xr   = (64'd1686629713 * longint'(k)) >> TBL_BITS;
        x2   = (xr * xr) >> 30;
        term = 64'd1 << 30;
        acc  = longint'(term);
        for (longint unsigned n = 1; n <= 12; n++) begin
          term = ((term * x2) >> 30) / ((2 * n - 1) * (2 * n));
          if (n[0]) begin
            acc = acc - longint'(term);
          end else begin
            acc = acc + longint'(term);
          end
        end
        if (acc < 0) acc = 0;
        if (acc > (longint'(1) << 30)) acc = longint'(1) << 30;
        cos_quarter[k] = int'((longint'(acc) * 32767 + (longint'(1) << 29)) >> 30);
      end
      mode           = MODE_AM_SC;
      freq_word      = '0;
      phase_word     = '0;
      carrier_offset = '0;
      angle_gain     = '0;
      carrier_phase  = '0;
      fm_sum         = '0;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatches++;
    endtask

    function void set_reg(cfg_reg_t idx, bit [31:0] val);
      case (idx)
        REG_MODE:       mode = mode_t'(val[1:0]);
        REG_FREQ_WORD:  freq_word = val;
        REG_PHASE_WORD: phase_word = val;
        REG_OFFSET:     carrier_offset = val[15:0];
        REG_ANGLE_GAIN: angle_gain = val;
        default: ;
      endcase
    endfunction

    // Quarter-wave lookup: top two angle bits pick the quadrant.
    function int cos_at(bit [31:0] ang);
      int f;
      f = int'((ang >> (30 - TBL_BITS)) & (TBL_N - 1));
      case (ang[31:30])
        2'd0:    return cos_quarter[f];
        2'd1:    return -cos_quarter[TBL_N - f];
        2'd2:    return -cos_quarter[f];
        default: return cos_quarter[TBL_N - f];
      endcase
    endfunction

    function void take_sample(logic signed [15:0] s, logic bs);
      longint    x;
      longint    y;
      bit [31:0] xw;
      bit [31:0] ang;
      x  = s;
      xw = {{16{s[15]}}, s};
      if (bs) begin
        carrier_phase = '0;
        block_starts++;
      end
      ang = carrier_phase + phase_word;
      mode_samples[mode]++;
      case (mode)
        MODE_AM_SC:      y = (x * cos_at(ang) + 16384) >>> 15;
        MODE_AM_CARRIER: y = ((x - longint'(carrier_offset)) * cos_at(ang) + 16384) >>> 15;
        MODE_FM: begin
          // The running sum includes the current sample and survives block starts.
          fm_sum = fm_sum + xw;
          ang    = ang + angle_gain * fm_sum;
          y      = cos_at(ang);
        end
        default: begin
          ang = ang + angle_gain * xw;
          y   = cos_at(ang);
        end
      endcase
      carrier_phase = carrier_phase + freq_word;
      expected_modulated.push_back(y[16:0]);
    endfunction

    task check_modulated(logic [16:0] got);
      logic [16:0] want;
      if (expected_modulated.size() == 0) begin
        report($sformatf("output beat 0x%05h with nothing expected", got));
      end else begin
        want = expected_modulated.pop_front();
        checked++;
        if (got !== want) begin
          report($sformatf("modulated got 0x%05h want 0x%05h", got, want));
        end
      end
    endtask
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // sample
  logic [0:0]  in_tuser   = '0;   // block_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // modulated (bits 16:0), zero filled
  logic        cfg_we     = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr  = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int hold_req     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  modulated_sample_board sb = new();

  analog_carrier_modulator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.take_sample(in_tdata, in_tuser[0]);
      if (out_tvalid && out_tready) sb.check_modulated(out_tdata[16:0]);
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired after %0d cycles without a beat", quiet_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_sample(input logic [15:0] s, input logic bs);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tuser  <= bs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop offering beats and wait until every expected result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_modulated.size() != 0) @(posedge clk);
  endtask

  task automatic write_word(input cfg_reg_t idx, input bit [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // Writes every register; unused upper bits of the narrow ones carry junk.
  task automatic apply_setting(input mode_t m, input bit [31:0] f, input bit [31:0] p,
                               input bit [15:0] o, input bit [31:0] g);
    bit [31:0] junk;
    junk = $urandom();
    write_word(REG_MODE, {junk[31:2], m});
    write_word(REG_FREQ_WORD, f);
    write_word(REG_PHASE_WORD, p);
    write_word(REG_OFFSET, {junk[15:0], o});
    write_word(REG_ANGLE_GAIN, g);
    cfg_we <= 1'b0;
  endtask

  function automatic bit [31:0] pick_word();
    case ($urandom_range(5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return $urandom_range(0, 65535);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [15:0] s;
    bit   [15:0] offs;
    bit   [31:0] gain;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: quarter-turn steps walk all four quadrants at full scale.
    apply_setting(MODE_AM_SC, 32'h4000_0000, 32'h0, 16'h0, 32'h0);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0001, 1'b0);
    drain();
    // Most negative offset pushes the AM result past 16 bits.
    apply_setting(MODE_AM_CARRIER, 32'hFFFF_FFFF, 32'h2000_0000, 16'h8000, 32'h0);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    drain();
    apply_setting(MODE_AM_CARRIER, 32'h0, 32'h0, 16'h7FFF, 32'h0);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    drain();
    // FM sum keeps accumulating across the second block start.
    apply_setting(MODE_FM, 32'h0100_0000, 32'hFFFF_FFFF, 16'h0, 32'h0010_0000);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_sample(16'd100, 1'b0);
    send_sample(16'h0000, 1'b0);
    drain();
    // Zero gain leaves a plain carrier.
    apply_setting(MODE_FM, 32'h0300_0000, 32'h0, 16'h0, 32'h0);
    send_sample(16'd12345, 1'b1);
    send_sample(16'hFFFB, 1'b0);
    drain();
    apply_setting(MODE_PM, 32'h0, 32'h0, 16'h0, 32'h8000_0000);
    send_sample(16'h0001, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    drain();
    apply_setting(MODE_PM, 32'h1234_5678, 32'h0, 16'h0, 32'h7FFF_FFFF);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h0002, 1'b0);

    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      drain();
      in_idle_pct  = (chunk < 4) ? 13 : ((chunk < 8) ? 84 : 0);
      out_idle_pct = (chunk < 4) ? 84 : ((chunk < 8) ? 13 : 0);
      case ($urandom_range(3))
        0:       offs = 16'h8000;
        1:       offs = 16'h7FFF;
        2:       offs = 16'h0000;
        default: offs = $urandom();
      endcase
      case ($urandom_range(6))
        0:       gain = 32'h0;
        1:       gain = 32'h8000_0000;
        2:       gain = 32'h7FFF_FFFF;
        3:       gain = $urandom_range(1, 4096);
        4:       gain = -$urandom_range(1, 4096);
        default: gain = $urandom();
      endcase
      apply_setting(mode_t'(chunk % 4), pick_word(), pick_word(), offs, gain);
      // With no idling, a long receiver hold-off backs the pipeline up into in_tready.
      if (chunk == 9) hold_req <= hold_req + 1;
      for (int n = 0; n < CHUNK_BEATS; n++) begin
        case ($urandom_range(7))
          0:       s = 16'h7FFF;
          1:       s = 16'h8000;
          2:       s = 16'h0000;
          3:       s = 16'($urandom_range(0, 63)) - 16'd32;
          default: s = $urandom();
        endcase
        send_sample(s, $urandom_range(15) == 0);
      end
    end

    drain();
    repeat (3 * PIPE_DEPTH) @(posedge clk);
    if (sb.expected_modulated.size() != 0) begin
      sb.report($sformatf("%0d expected beats never arrived", sb.expected_modulated.size()));
    end
    $display("Run covered %0d samples: AM-SC %0d, AM-carrier %0d, FM %0d, PM %0d.",
             sb.checked + sb.expected_modulated.size(), sb.mode_samples[0],
             sb.mode_samples[1], sb.mode_samples[2], sb.mode_samples[3]);
    $display("%0d block starts, %0d beats checked, %0d mismatches.",
             sb.block_starts, sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
